// ===== hdl/adsr_pkg.sv =====
// Shared types and constants for the envelope generator.
`timescale 1ns / 1ps

package adsr_pkg;

   localparam int NUM_CHANNELS = 16;
   localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // channel status bits: 1:0 envelope, 2 echo, 3 stop, 4 start
   localparam logic [4:0] STS_ENV     = 5'h03;
   localparam logic [4:0] STS_ATTACK  = 5'h03;
   localparam logic [4:0] STS_DECAY   = 5'h02;
   localparam logic [4:0] STS_SUSTAIN = 5'h01;
   localparam logic [4:0] STS_ECHO    = 5'h04;
   localparam logic [4:0] STS_STOP    = 5'h08;
   localparam logic [4:0] STS_START   = 5'h10;

   localparam logic [2:0] PH_IDLE    = 3'd0;
   localparam logic [2:0] PH_ATTACK  = 3'd1;
   localparam logic [2:0] PH_DECAY   = 3'd2;
   localparam logic [2:0] PH_SUSTAIN = 3'd3;
   localparam logic [2:0] PH_RELEASE = 3'd4;
   localparam logic [2:0] PH_ECHO    = 3'd5;

   typedef enum logic [1:0] {
      CMD_TICK = 2'd0,
      CMD_ON   = 2'd1,
      CMD_OFF  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [3:0] channel;
      cmd_type    cmd;
      logic       in_range;
      logic [7:0] attack_rate;
      logic [7:0] decay_factor;
      logic [7:0] sustain_level;
      logic [7:0] release_factor;
      logic [7:0] echo_level;
      logic [7:0] echo_frames;
      logic [7:0] right_volume;
      logic [7:0] left_volume;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== hdl/adsr_echo_envelope.sv =====
// Top level of the multi-channel envelope generator with echo tail.
// An accepted item waits in the queue, then passes the back end's step, scale, right and left states before its strobe.
// The back end finishes one item's step, scale, right, left sequence before it takes the next item from the queue.
// A two-item queue accepts while the back end works; busy is high only when it is full.
// Synchronous reset clears all channels, the queue and the strobe; master volume resets to 15.
// Results are never held off: each is shown for exactly one cycle.
`timescale 1ns / 1ps

module adsr_echo_envelope import adsr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [3:0] req_channel,
   input  logic [1:0] req_command,
   input  logic [7:0] req_attack_rate,
   input  logic [7:0] req_decay_factor,
   input  logic [7:0] req_sustain_level,
   input  logic [7:0] req_release_factor,
   input  logic [7:0] req_echo_level,
   input  logic [7:0] req_echo_frames,
   input  logic [7:0] req_right_volume,
   input  logic [7:0] req_left_volume,
   input  logic       csr_write_enable,
   input  logic [3:0] csr_write_data,
   output logic       rsp_strobe,
   output logic [3:0] rsp_out_channel,
   output logic       rsp_active,
   output logic [2:0] rsp_phase,
   output logic [7:0] rsp_level,
   output logic [7:0] rsp_right_level,
   output logic [7:0] rsp_left_level
);

   queue_status_type q_status;
   item_type         push_item;
   item_type         head_item;
   logic             push;
   logic             pop;

   adsr_front u_front (
      .start              (start),
      .busy               (busy),
      .req_channel        (req_channel),
      .req_command        (req_command),
      .req_attack_rate    (req_attack_rate),
      .req_decay_factor   (req_decay_factor),
      .req_sustain_level  (req_sustain_level),
      .req_release_factor (req_release_factor),
      .req_echo_level     (req_echo_level),
      .req_echo_frames    (req_echo_frames),
      .req_right_volume   (req_right_volume),
      .req_left_volume    (req_left_volume),
      .q_status           (q_status),
      .push               (push),
      .push_item          (push_item)
   );

   adsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   adsr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .q_status         (q_status),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_channel  (rsp_out_channel),
      .rsp_active       (rsp_active),
      .rsp_phase        (rsp_phase),
      .rsp_level        (rsp_level),
      .rsp_right_level  (rsp_right_level),
      .rsp_left_level   (rsp_left_level)
   );

   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on consecutive cycles");

   a_inactive_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_active) |-> (rsp_right_level == 8'd0 && rsp_left_level == 8'd0))
      else $error("inactive channel reported nonzero stereo level");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   a_busy_queue: assert property (@(posedge clock) disable iff (reset)
      busy |-> !q_status.empty)
      else $error("busy with an empty queue");

endmodule

// ===== hdl/adsr_front.sv =====
// Front end: takes items, classifies command and channel range, pushes to the queue.
`timescale 1ns / 1ps

module adsr_front import adsr_pkg::*; (
   input  logic             start,
   output logic             busy,
   input  logic [3:0]       req_channel,
   input  logic [1:0]       req_command,
   input  logic [7:0]       req_attack_rate,
   input  logic [7:0]       req_decay_factor,
   input  logic [7:0]       req_sustain_level,
   input  logic [7:0]       req_release_factor,
   input  logic [7:0]       req_echo_level,
   input  logic [7:0]       req_echo_frames,
   input  logic [7:0]       req_right_volume,
   input  logic [7:0]       req_left_volume,
   input  queue_status_type q_status,
   output logic             push,
   output item_type         push_item
);

   logic in_range;

   assign in_range = ({1'b0, req_channel} < 5'(NUM_CHANNELS));
   assign busy     = q_status.full;
   assign push     = start && !q_status.full;

   always_comb begin
      push_item.channel        = req_channel;
      push_item.in_range       = in_range;
      push_item.cmd            = in_range ? cmd_type'(req_command) : CMD_NONE;
      push_item.attack_rate    = req_attack_rate;
      push_item.decay_factor   = req_decay_factor;
      push_item.sustain_level  = req_sustain_level;
      push_item.release_factor = req_release_factor;
      push_item.echo_level     = req_echo_level;
      push_item.echo_frames    = req_echo_frames;
      push_item.right_volume   = req_right_volume;
      push_item.left_volume    = req_left_volume;
   end

endmodule

// ===== hdl/adsr_queue.sv =====
// Short item queue between front and back end.
`timescale 1ns / 1ps

module adsr_queue import adsr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         head_item,
   output queue_status_type status
);

   item_type            entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_in;

   assign wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;

   assign head_item    = entries_ff[rd_ptr_ff];
   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            entries_ff[wr_ptr_ff] <= push_item;
            wr_ptr_ff             <= wr_ptr_in;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_in;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// ===== hdl/adsr_back.sv =====
// Back end: channel state, envelope step, master and pan scaling, result strobe.
`timescale 1ns / 1ps

module adsr_back import adsr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [3:0]       csr_write_data,
   input  queue_status_type q_status,
   input  item_type         head_item,
   output logic             pop,
   output logic             rsp_strobe,
   output logic [3:0]       rsp_out_channel,
   output logic             rsp_active,
   output logic [2:0]       rsp_phase,
   output logic [7:0]       rsp_level,
   output logic [7:0]       rsp_right_level,
   output logic [7:0]       rsp_left_level
);

   localparam logic [1:0] ENV_ATTACK = 2'd3;
   localparam logic [1:0] ENV_DECAY  = 2'd2;
   localparam logic [1:0] ENV_SUST   = 2'd1;
   localparam int         B_ECHO     = 2;
   localparam int         B_STOP     = 3;
   localparam int         B_START    = 4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_SCALE,
      ST_RIGHT,
      ST_LEFT
   } state_type;

   function automatic logic [2:0] phase_of(input logic [4:0] st);
      logic [2:0] ph;
      if (st == '0)            ph = PH_IDLE;
      else if (st[B_START])    ph = PH_ATTACK;
      else if (st[B_ECHO])     ph = PH_ECHO;
      else if (st[B_STOP])     ph = PH_RELEASE;
      else begin
         case (st[1:0])
            ENV_ATTACK: ph = PH_ATTACK;
            ENV_DECAY:  ph = PH_DECAY;
            ENV_SUST:   ph = PH_SUSTAIN;
            default:    ph = PH_IDLE;
         endcase
      end
      return ph;
   endfunction

   state_type           state_ff;
   logic                strobe_ff;
   logic [3:0]          master_ff;
   item_type            cur_ff;
   logic [4:0]          status_ff [NUM_CHANNELS];
   logic [7:0]          level_ff  [NUM_CHANNELS];
   logic [7:0]          count_ff  [NUM_CHANNELS];
   logic [3:0]          res_channel_ff;
   logic                res_active_ff;
   logic [2:0]          res_phase_ff;
   logic [7:0]          res_level_ff;
   logic [7:0]          scaled_ff;
   logic [7:0]          right_ff;
   logic [7:0]          left_ff;

   logic [CH_IDX_W-1:0] idx;
   logic [4:0]          st;
   logic [7:0]          env;
   logic [7:0]          cnt;
   logic [4:0]          st_a;
   logic [7:0]          base;
   logic [8:0]          sum;
   logic [7:0]          mult_b;
   logic [15:0]         prod;
   logic [7:0]          prod_hi;
   logic                to_echo;
   logic [4:0]          status_in;
   logic [7:0]          level_in;
   logic [7:0]          count_in;
   logic [4:0]          mvol;
   logic [12:0]         mprod;
   logic [15:0]         rprod;
   logic [15:0]         lprod;

   assign idx     = cur_ff.channel[CH_IDX_W-1:0];
   assign st      = status_ff[idx];
   assign env     = level_ff[idx];
   assign cnt     = count_ff[idx];
   assign st_a    = st[B_START] ? STS_ATTACK : st;
   assign base    = st[B_START] ? 8'd0 : env;
   assign sum     = {1'b0, base} + {1'b0, cur_ff.attack_rate};
   assign mult_b  = st[B_STOP] ? cur_ff.release_factor : cur_ff.decay_factor;
   assign prod    = env * mult_b;
   assign prod_hi = prod[15:8];

   // one envelope step, key-on or key-off update for the addressed channel
   always_comb begin
      status_in = st;
      level_in  = env;
      count_in  = cnt;
      to_echo   = 1'b0;
      unique case (cur_ff.cmd)
         CMD_TICK: begin
            if (st != '0) begin
               if (st[B_START] && st[B_STOP]) begin
                  status_in = '0;
               end else if (!st[B_START] && st[B_ECHO]) begin
                  count_in = cnt - 8'd1;
                  if (cnt <= 8'd1) status_in = '0;
               end else if (!st[B_START] && st[B_STOP]) begin
                  level_in = prod_hi;
                  to_echo  = (prod_hi <= cur_ff.echo_level);
               end else if (!st[B_START] && st[1:0] == ENV_DECAY) begin
                  level_in = prod_hi;
                  if (prod_hi <= cur_ff.sustain_level) begin
                     level_in = cur_ff.sustain_level;
                     if (cur_ff.sustain_level == 8'd0) to_echo = 1'b1;
                     else status_in = {st[4:2], ENV_SUST};
                  end
               end else if (st_a[1:0] == ENV_ATTACK) begin
                  status_in = st_a;
                  if (sum >= 9'h0FF) begin
                     level_in  = 8'hFF;
                     status_in = {st_a[4:2], ENV_DECAY};
                  end else begin
                     level_in = sum[7:0];
                  end
               end
               if (to_echo) begin
                  if (cur_ff.echo_level == 8'd0) begin
                     status_in = '0;
                     level_in  = env;
                  end else begin
                     level_in  = cur_ff.echo_level;
                     status_in = status_in | STS_ECHO;
                  end
               end
            end
         end
         CMD_ON: begin
            status_in = STS_START;
            count_in  = cur_ff.echo_frames;
         end
         CMD_OFF: begin
            if (st != '0) status_in = st | STS_STOP;
         end
         default: begin
         end
      endcase
   end

   assign mvol  = {1'b0, master_ff} + 5'd1;
   assign mprod = mvol * res_level_ff;
   assign rprod = cur_ff.right_volume * scaled_ff;
   assign lprod = cur_ff.left_volume * scaled_ff;

   assign pop = ((state_ff == ST_IDLE) || (state_ff == ST_LEFT)) && !q_status.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
         master_ff <= 4'hF;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            status_ff[i] <= '0;
            level_ff[i]  <= '0;
            count_ff[i]  <= '0;
         end
      end else begin
         strobe_ff <= 1'b0;
         if (csr_write_enable) master_ff <= csr_write_data;
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_status.empty) begin
                  cur_ff   <= head_item;
                  state_ff <= ST_STEP;
               end
            end
            ST_STEP: begin
               if (cur_ff.in_range) begin
                  status_ff[idx] <= status_in;
                  level_ff[idx]  <= level_in;
                  count_ff[idx]  <= count_in;
               end
               res_channel_ff <= cur_ff.channel;
               res_active_ff  <= cur_ff.in_range && (status_in != '0);
               res_phase_ff   <= cur_ff.in_range ? phase_of(status_in) : PH_IDLE;
               res_level_ff   <= cur_ff.in_range ? level_in : 8'd0;
               state_ff       <= ST_SCALE;
            end
            ST_SCALE: begin
               scaled_ff <= res_active_ff ? mprod[11:4] : 8'd0;
               state_ff  <= ST_RIGHT;
            end
            ST_RIGHT: begin
               right_ff <= rprod[15:8];
               state_ff <= ST_LEFT;
            end
            ST_LEFT: begin
               left_ff   <= lprod[15:8];
               strobe_ff <= 1'b1;
               if (!q_status.empty) begin
                  cur_ff   <= head_item;
                  state_ff <= ST_STEP;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // res_* hold through the strobe cycle; the next step overwrites them at its end
   assign rsp_strobe      = strobe_ff;
   assign rsp_out_channel = res_channel_ff;
   assign rsp_active      = res_active_ff;
   assign rsp_phase       = res_phase_ff;
   assign rsp_level       = res_level_ff;
   assign rsp_right_level = right_ff;
   assign rsp_left_level  = left_ff;

endmodule
